// ===== hw/rtl/fbc_pkg.sv =====
// ----------------------------------------------------------------------------
// fbc_pkg: shared types and constants for the frustum box classifier
// Plane register layout, register indexes, result codes and arithmetic widths.
// ----------------------------------------------------------------------------
package fbc_pkg;

   // Corner coordinate width, signed, 8 fraction bits
   localparam int COORD_BITS = 20;

   localparam int PLANE_COUNT  = 6;
   localparam int CSR_BITS     = 64;
   localparam int CSR_IDX_BITS = 3;
   localparam int MARGIN_BITS  = 8;
   localparam int NORM_BITS    = 12;   // Q1.10
   localparam int NORM_FRAC    = 10;
   localparam int OFFSET_BITS  = 28;   // Q.8

   // Product of normal and coordinate, then sum of three
   localparam int PROD_BITS = NORM_BITS + COORD_BITS;
   localparam int DOT_BITS  = PROD_BITS + 2;
   // (offset + margin) scaled to Q.18
   localparam int THR_BITS  = OFFSET_BITS + 1 + NORM_FRAC;
   localparam int CMP_BITS  = (DOT_BITS > THR_BITS) ? DOT_BITS : THR_BITS;

   localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = MARGIN_BITS'(3);

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_PLANE_TOP,
      CSR_PLANE_BOTTOM,
      CSR_PLANE_RIGHT,
      CSR_PLANE_LEFT,
      CSR_PLANE_FAR,
      CSR_PLANE_NEAR,
      CSR_INSIDE_MARGIN
   } csr_index_type;

   typedef enum logic [1:0] {
      CLASS_OUTSIDE    = 2'd0,
      CLASS_INTERSECTS = 2'd1,
      CLASS_INSIDE     = 2'd2
   } box_class_type;

   // Packed so that it overlays the 64-bit register directly
   typedef struct packed {
      logic signed [OFFSET_BITS-1:0] offset;
      logic signed [NORM_BITS-1:0]   nz;
      logic signed [NORM_BITS-1:0]   ny;
      logic signed [NORM_BITS-1:0]   nx;
   } plane_type;

   typedef struct packed {
      plane_type [PLANE_COUNT-1:0] plane;
      logic [MARGIN_BITS-1:0]      margin;
   } cfg_type;

endpackage

// ===== hw/rtl/frustum_box_classifier.sv =====
// ----------------------------------------------------------------------------
// frustum_box_classifier: box versus view-frustum classification
// Path: input register, then plane tests and flag update into the result
//   register; a closing corner waits while the result register stays full.
// One corner per cycle outside that wait; six plane tests run in parallel lanes.
// Reset (synchronous): flags and valids clear, planes zero, margin 3/256.
// ----------------------------------------------------------------------------
module frustum_box_classifier (
   input  logic                                   clock,
   input  logic                                   reset,
   // corner transactions
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [fbc_pkg::COORD_BITS-1:0]  req_corner_x,
   input  logic signed [fbc_pkg::COORD_BITS-1:0]  req_corner_y,
   input  logic signed [fbc_pkg::COORD_BITS-1:0]  req_corner_z,
   input  logic                                   req_last_corner,
   // result transactions
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [1:0]                             rsp_box_class,
   // configuration writes
   input  logic                                   csr_wr_en,
   input  logic [fbc_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [fbc_pkg::CSR_BITS-1:0]           csr_wdata
);

   localparam logic [fbc_pkg::PLANE_COUNT-1:0] ALL_PLANES = '1;

   fbc_pkg::cfg_type cfg;

   // Input register stage
   logic                                  s1_vld_ff, s1_vld_in;
   logic                                  s1_last_ff, s1_last_in;
   logic signed [fbc_pkg::COORD_BITS-1:0] s1_x_ff, s1_x_in;
   logic signed [fbc_pkg::COORD_BITS-1:0] s1_y_ff, s1_y_in;
   logic signed [fbc_pkg::COORD_BITS-1:0] s1_z_ff, s1_z_in;

   // Per-plane records for the box in progress
   logic [fbc_pkg::PLANE_COUNT-1:0] saw_in_ff, saw_in_in;
   logic [fbc_pkg::PLANE_COUNT-1:0] saw_out_ff, saw_out_in;

   // Result register
   logic                   rsp_valid_ff, rsp_valid_in;
   fbc_pkg::box_class_type rsp_class_ff, rsp_class_in;

   logic [fbc_pkg::PLANE_COUNT-1:0] pass;
   logic [fbc_pkg::PLANE_COUNT-1:0] saw_in_upd, saw_out_upd;
   logic                            s1_adv;
   logic                            req_fire;
   fbc_pkg::box_class_type          box_class;

   fbc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // One lane per plane, all working on the corner in the input register
   for (genvar p = 0; p < fbc_pkg::PLANE_COUNT; p++) begin : g_plane
      fbc_plane_test u_test (
         .plane    (cfg.plane[p]),
         .margin   (cfg.margin),
         .corner_x (s1_x_ff),
         .corner_y (s1_y_ff),
         .corner_z (s1_z_ff),
         .pass     (pass[p])
      );
   end

   // A corner that closes no box never needs the result register, so it
   // always moves on. A closing corner waits only if the result register
   // is full and not being emptied this cycle.
   assign s1_adv    = s1_vld_ff && (!s1_last_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_vld_ff || s1_adv;
   assign req_fire  = req_valid && req_ready;

   // Every plane records exactly one of inside or outside per corner
   assign saw_in_upd  = saw_in_ff | pass;
   assign saw_out_upd = saw_out_ff | ~pass;

   always_comb begin
      if (saw_in_upd != ALL_PLANES) begin
         box_class = fbc_pkg::CLASS_OUTSIDE;     // some plane has no inside corner
      end else if (saw_out_upd != '0) begin
         box_class = fbc_pkg::CLASS_INTERSECTS;
      end else begin
         box_class = fbc_pkg::CLASS_INSIDE;
      end
   end

   always_comb begin
      s1_vld_in    = s1_vld_ff;
      s1_last_in   = s1_last_ff;
      s1_x_in      = s1_x_ff;
      s1_y_in      = s1_y_ff;
      s1_z_in      = s1_z_ff;
      saw_in_in    = saw_in_ff;
      saw_out_in   = saw_out_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_class_in = rsp_class_ff;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (s1_adv) begin
         s1_vld_in = 1'b0;
         if (s1_last_ff) begin
            // box closed: emit and start the next one clean
            rsp_valid_in = 1'b1;
            rsp_class_in = box_class;
            saw_in_in    = '0;
            saw_out_in   = '0;
         end else begin
            saw_in_in  = saw_in_upd;
            saw_out_in = saw_out_upd;
         end
      end

      if (req_fire) begin
         s1_vld_in  = 1'b1;
         s1_last_in = req_last_corner;
         s1_x_in    = req_corner_x;
         s1_y_in    = req_corner_y;
         s1_z_in    = req_corner_z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         saw_in_ff    <= '0;
         saw_out_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_vld_ff    <= s1_vld_in;
         saw_in_ff    <= saw_in_in;
         saw_out_ff   <= saw_out_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      s1_last_ff   <= s1_last_in;
      s1_x_ff      <= s1_x_in;
      s1_y_ff      <= s1_y_in;
      s1_z_ff      <= s1_z_in;
      rsp_class_ff <= rsp_class_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_box_class = rsp_class_ff;

   // Closing corner leaves a result waiting and the records cleared
   a_close_emits: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_last_ff) |=>
         (rsp_valid_ff && saw_in_ff == '0 && saw_out_ff == '0))
      else $error("closing corner did not produce a result or clear records");

   // A corner that does not close a box never creates a result
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && !s1_last_ff && (!rsp_valid_ff || rsp_ready)) |=> !rsp_valid_ff)
      else $error("result appeared without a closing corner");

   // Records cover either no plane or every plane
   a_records_whole: assert property (@(posedge clock) disable iff (reset)
      ((saw_in_ff | saw_out_ff) == '0) || ((saw_in_ff | saw_out_ff) == ALL_PLANES))
      else $error("plane records partially set");

endmodule

// ===== hw/rtl/fbc_csr.sv =====
// ----------------------------------------------------------------------------
// fbc_csr: configuration registers
// Six plane registers and the inside margin, write-only.
// ----------------------------------------------------------------------------
module fbc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [fbc_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [fbc_pkg::CSR_BITS-1:0]        csr_wdata,
   output fbc_pkg::cfg_type                    cfg
);

   fbc_pkg::plane_type [fbc_pkg::PLANE_COUNT-1:0] plane_ff, plane_in;
   logic [fbc_pkg::MARGIN_BITS-1:0]               margin_ff, margin_in;

   always_comb begin
      plane_in  = plane_ff;
      margin_in = margin_ff;
      if (csr_wr_en) begin
         case (fbc_pkg::csr_index_type'(csr_index))
            fbc_pkg::CSR_PLANE_TOP:
               plane_in[fbc_pkg::CSR_PLANE_TOP] = fbc_pkg::plane_type'(csr_wdata);
            fbc_pkg::CSR_PLANE_BOTTOM:
               plane_in[fbc_pkg::CSR_PLANE_BOTTOM] = fbc_pkg::plane_type'(csr_wdata);
            fbc_pkg::CSR_PLANE_RIGHT:
               plane_in[fbc_pkg::CSR_PLANE_RIGHT] = fbc_pkg::plane_type'(csr_wdata);
            fbc_pkg::CSR_PLANE_LEFT:
               plane_in[fbc_pkg::CSR_PLANE_LEFT] = fbc_pkg::plane_type'(csr_wdata);
            fbc_pkg::CSR_PLANE_FAR:
               plane_in[fbc_pkg::CSR_PLANE_FAR] = fbc_pkg::plane_type'(csr_wdata);
            fbc_pkg::CSR_PLANE_NEAR:
               plane_in[fbc_pkg::CSR_PLANE_NEAR] = fbc_pkg::plane_type'(csr_wdata);
            fbc_pkg::CSR_INSIDE_MARGIN:
               margin_in = csr_wdata[fbc_pkg::MARGIN_BITS-1:0];
            default: begin
               // unmapped index: ignored
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff  <= '0;
         margin_ff <= fbc_pkg::MARGIN_RESET;
      end else begin
         plane_ff  <= plane_in;
         margin_ff <= margin_in;
      end
   end

   assign cfg.plane  = plane_ff;
   assign cfg.margin = margin_ff;

endmodule

// ===== hw/rtl/fbc_plane_test.sv =====
// ----------------------------------------------------------------------------
// fbc_plane_test: one plane side test
// dot(n, corner) >= (offset + margin) * 2^10, exact in fixed point.
// ----------------------------------------------------------------------------
module fbc_plane_test (
   input  fbc_pkg::plane_type                     plane,
   input  logic [fbc_pkg::MARGIN_BITS-1:0]        margin,
   input  logic signed [fbc_pkg::COORD_BITS-1:0]  corner_x,
   input  logic signed [fbc_pkg::COORD_BITS-1:0]  corner_y,
   input  logic signed [fbc_pkg::COORD_BITS-1:0]  corner_z,
   output logic                                   pass
);

   logic signed [fbc_pkg::PROD_BITS-1:0] prod_x, prod_y, prod_z;
   logic signed [fbc_pkg::DOT_BITS-1:0]  dot;
   logic signed [fbc_pkg::CMP_BITS-1:0]  thr_sum, thr;

   // Q.10 x Q.8 -> Q.18
   assign prod_x = fbc_pkg::PROD_BITS'($signed(plane.nx))
                 * fbc_pkg::PROD_BITS'(corner_x);
   assign prod_y = fbc_pkg::PROD_BITS'($signed(plane.ny))
                 * fbc_pkg::PROD_BITS'(corner_y);
   assign prod_z = fbc_pkg::PROD_BITS'($signed(plane.nz))
                 * fbc_pkg::PROD_BITS'(corner_z);

   assign dot = fbc_pkg::DOT_BITS'(prod_x) + fbc_pkg::DOT_BITS'(prod_y)
              + fbc_pkg::DOT_BITS'(prod_z);

   assign thr_sum = fbc_pkg::CMP_BITS'($signed(plane.offset))
                  + fbc_pkg::CMP_BITS'($signed({1'b0, margin}));
   assign thr     = thr_sum <<< fbc_pkg::NORM_FRAC;

   assign pass = (fbc_pkg::CMP_BITS'(dot) >= thr);

endmodule
